// ===== hw/rtl/mhpq_pkg.sv =====
// Package for the max-heap priority queue: request, response and heap entry
// types, status and request codes, and the default capacity.
// No dependencies.
package mhpq_pkg;

  localparam int HEAP_CAPACITY = 1024;

  localparam int KEY_W = 32;
  localparam int ID_W  = 31;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_ID = -32'sd1;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   item_id;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   out_key;
    logic signed [31:0] out_id;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

endpackage

// ===== hw/rtl/mhpq_ram.sv =====
// Heap storage: one write port and two read ports, read data registered.
// Depends on mhpq_pkg for the entry type.
module mhpq_ram #(
  parameter int  DEPTH = mhpq_pkg::HEAP_CAPACITY,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  mhpq_pkg::entry_t        wdata,
  input  logic [AW-1:0]           raddr_a,
  input  logic [AW-1:0]           raddr_b,
  output mhpq_pkg::entry_t        rdata_a,
  output mhpq_pkg::entry_t        rdata_b
);
  import mhpq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/mhpq_seq.sv =====
// Heap sequencer: takes one request at a time, walks the heap in memory
// one level per cycle and presents the response. Depends on mhpq_pkg.
module mhpq_seq #(
  parameter int  CAPACITY = mhpq_pkg::HEAP_CAPACITY,
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mhpq_pkg::req_t    req,
  output logic              res_valid,
  input  logic              res_stall,
  output mhpq_pkg::rsp_t    res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output mhpq_pkg::entry_t  mem_wdata,
  output logic [AW-1:0]     mem_raddr_a,
  output logic [AW-1:0]     mem_raddr_b,
  input  mhpq_pkg::entry_t  mem_rdata_a,
  input  mhpq_pkg::entry_t  mem_rdata_b
);
  import mhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = AW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_DN_LOAD, S_DN, S_WR_ITEM, S_DONE
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  entry_t        item, item_next;
  rsp_t          res_next;

  logic [PW-1:0] n_ext, left, right, big, nleft;
  logic          take_right;
  entry_t        big_ent;
  logic [AW-1:0] par;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW-1:0] pm1;
    pm1 = p - AW'(1);
    return pm1 >> 1;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  // Child positions for the walk down; count already holds the reduced size.
  assign n_ext      = PW'(count);
  assign left       = {1'b0, pos, 1'b1};
  assign right      = left + PW'(1);
  assign take_right = (right < n_ext) && (mem_rdata_b.key > mem_rdata_a.key);
  assign big        = take_right ? right : left;
  assign big_ent    = take_right ? mem_rdata_b : mem_rdata_a;
  assign nleft      = {1'b0, big[AW-1:0], 1'b1};
  assign par        = parent_of(pos);

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    item_next   = item;
    res_next    = res;
    mem_we      = 1'b0;
    mem_waddr   = pos;
    mem_wdata   = item;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.req_type == REQ_INSERT) begin
            if (count == CAP_C) begin
              res_next   = '{status: ST_FULL, out_key: '0, out_id: '0};
              state_next = S_DONE;
            end else begin
              res_next   = '{status: ST_OK, out_key: '0, out_id: '0};
              item_next  = '{key: req.key, id: req.item_id};
              pos_next   = count[AW-1:0];
              count_next = count + CW'(1);
              if (count == '0) begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '{key: req.key, id: req.item_id};
                state_next = S_DONE;
              end else begin
                mem_raddr_a = parent_of(count[AW-1:0]);
                state_next  = S_UP;
              end
            end
          end else begin
            if (count == '0) begin
              res_next   = '{status: ST_EMPTY, out_key: '0, out_id: EMPTY_ID};
              state_next = S_DONE;
            end else begin
              mem_raddr_a = '0;
              mem_raddr_b = AW'(count - CW'(1));
              count_next  = count - CW'(1);
              pos_next    = '0;
              state_next  = S_DN_LOAD;
            end
          end
        end
      end
      S_UP: begin
        // The hole sits at pos; the parent moves down while it is smaller.
        if (mem_rdata_a.key < item.key) begin
          mem_we    = 1'b1;
          mem_waddr = pos;
          mem_wdata = mem_rdata_a;
          pos_next  = par;
          if (par == '0) begin
            state_next = S_WR_ITEM;
          end else begin
            mem_raddr_a = parent_of(par);
          end
        end else begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_LOAD: begin
        res_next  = '{status: ST_OK, out_key: mem_rdata_a.key,
                      out_id: {1'b0, mem_rdata_a.id}};
        item_next = mem_rdata_b;
        if (n_ext <= PW'(1)) begin
          mem_we     = 1'b1;
          mem_waddr  = '0;
          mem_wdata  = mem_rdata_b;
          state_next = S_DONE;
        end else begin
          mem_raddr_a = AW'(1);
          mem_raddr_b = AW'(2);
          state_next  = S_DN;
        end
      end
      S_DN: begin
        // The larger child moves up unless the carried entry is strictly greater.
        if (item.key > big_ent.key) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos;
          mem_wdata = big_ent;
          pos_next  = big[AW-1:0];
          if (nleft >= n_ext) begin
            state_next = S_WR_ITEM;
          end else begin
            mem_raddr_a = nleft[AW-1:0];
            mem_raddr_b = nleft[AW-1:0] + AW'(1);
          end
        end
      end
      S_WR_ITEM: begin
        mem_we     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!res_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    pos  <= pos_next;
    item <= item_next;
    res  <= res_next;
  end

endmodule

// ===== hw/rtl/max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue of CAPACITY entries (key and id), kept in a
// dual-read-port synchronous memory. One request is in progress at a time.
// An insert places the new entry at the end and moves it up one level per
// step; a remove returns the root, moves the last entry to the root and moves
// it down one level per step. The time taken is set by the one memory access
// per heap level. The response then sits in an output register, so the next
// request can start while it waits.
// Depends on mhpq_pkg, mhpq_ram and mhpq_seq.
module max_heap_priority_queue_unit #(
  parameter int CAPACITY = mhpq_pkg::HEAP_CAPACITY
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mhpq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mhpq_pkg::rsp_t  rsp
);
  import mhpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          res_valid, res_stall;
  rsp_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  entry_t        mem_wdata, mem_rdata_a, mem_rdata_b;

  mhpq_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  mhpq_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // Output register: it takes a new response whenever it is empty or its
  // current transfer completes.
  assign res_stall = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!res_stall) begin
      rsp_valid <= res_valid;
    end
    if (res_valid && !res_stall) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("sequencer took a request but did not go busy");

  a_result_registered: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall |=> rsp_valid)
    else $error("response handed over but output register not valid");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.out_id == EMPTY_ID && rsp.out_key == '0)
    else $error("empty response carries wrong fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_FULL || rsp.status == ST_EMPTY)
    else $error("response carries an undefined status code");
`endif

endmodule
